/* rtl/core/slru_pkg.sv */
package slru_pkg;

  localparam int SETS_DEF     = 64;
  localparam int WAYS_DEF     = 8;
  localparam int TAG_BITS_DEF = 20;

  typedef enum logic [1:0] {
    OP_INV    = 2'd0,
    OP_HIT    = 2'd1,
    OP_FILL   = 2'd2,
    OP_VICTIM = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_PROMO_SHIFT = 3'd0,
    CFG_BYP_EN      = 3'd1,
    CFG_AGING_EN    = 3'd2,
    CFG_INIT_LEVEL  = 3'd3,
    CFG_VIRT_SHIFT  = 3'd4,
    CFG_MIN_LEVEL   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  set_index;
    logic [2:0]  line_way;
    logic [19:0] line_tag;
    logic [31:0] time_now;
    logic [31:0] random_a;
    logic [31:0] random_b;
  } req_t;

  typedef struct packed {
    logic [2:0] victim_way;
    logic       bypass_fill;
    logic [4:0] bypass_level_out;
  } rsp_t;

  // oldest search status, way indexes cover up to 32 ways
  typedef struct packed {
    logic       done;
    logic       ref_found;
    logic [4:0] ref_way;
    logic       nref_found;
    logic [4:0] nref_way;
  } scan_res_t;

  typedef struct packed {
    logic [4:0] level;
    logic       on;
  } lvl_t;

  // succeed when the low k bits are all zero
  function automatic logic draw(logic [31:0] rnd, logic [4:0] k);
    logic [31:0] m;
    m = (32'h1 << k) - 32'h1;
    return (rnd & m) == 32'h0;
  endfunction

  function automatic lvl_t level_raise(lvl_t cur, logic [4:0] min_lvl);
    logic [5:0] v;
    lvl_t r;
    r = cur;
    v = {1'b0, cur.level} + 6'd1;
    if (v > {1'b0, min_lvl}) begin
      r.on = 1'b0;
      r.level = min_lvl;
    end else begin
      r.level = v[4:0];
    end
    return r;
  endfunction

  function automatic lvl_t level_lower(lvl_t cur, logic [4:0] min_lvl);
    lvl_t r;
    r = cur;
    if (!cur.on) begin
      r.on = 1'b1;
      r.level = min_lvl;
    end else if (cur.level != 5'd0) begin
      r.level = cur.level - 5'd1;
    end
    return r;
  endfunction

endpackage

/* rtl/core/segmented_lru_adaptive_bypass.sv */
// Channel  | Ports                               | Handshake
// request  | start, busy, request (req_t)        | taken when start & !busy
// result   | result_valid, result (rsp_t)        | one-cycle strobe, no stall
// config   | wr_en, wr_index, wr_data            | written when wr_en is high
// Invalidate, hit and fill pass through S_RD and S_FIN from accept to the result strobe.
// A victim request also passes through S_SCAN, where the oldest search walks the set
// row one way per cycle. Set metadata and episodes live in two RAMs with
// registered reads; one request is in flight at a time.
// Reset clears per-set valid bits at once, so no clearing pass is needed.
// The result strobe cannot be held off by the receiver.
module segmented_lru_adaptive_bypass import slru_pkg::*; #(
  parameter int SETS     = SETS_DEF,
  parameter int WAYS     = WAYS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       request,
  output logic       result_valid,
  output rsp_t       result,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [4:0] wr_data
);

  localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_AW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W  = WAYS * (33 + TAG_BITS);

  typedef struct packed {
    logic                valid;
    logic                virt;
    logic                skip;
    logic [WAY_AW-1:0]   way;
    logic [TAG_BITS-1:0] tag;
  } ep_t;

  localparam int EP_W = $bits(ep_t);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // config registers
  logic [4:0] promo_shift;
  logic       byp_en;
  logic       aging_en;
  logic [4:0] virt_shift;
  logic [4:0] min_level;
  lvl_t       lvl;
  lvl_t       lvl_next;
  lvl_t       lvl_res;

  req_t req_q;
  logic ign;
  logic [SETS-1:0] set_vld;

  logic [WAYS-1:0]                ref_q;
  logic [WAYS-1:0][31:0]          time_q;
  logic [WAYS-1:0][TAG_BITS-1:0]  tag_q;
  ep_t                            ep_q;
  logic [WAYS-1:0]                ref_n;
  logic [WAYS-1:0][31:0]          time_n;
  logic [WAYS-1:0][TAG_BITS-1:0]  tag_n;
  ep_t                            ep_n;

  logic [ROW_W-1:0]  row_rdata;
  logic [EP_W-1:0]   ep_rdata;
  logic [SET_AW-1:0] rd_set;
  logic [SET_AW-1:0] set_q;
  logic              wr_mem;
  logic              accept;
  logic              in_range;
  logic              scan_start;
  scan_res_t         scan_res;

  logic [WAY_AW-1:0]   w;
  logic [WAY_AW-1:0]   vic;
  logic                byp;
  logic [TAG_BITS-1:0] tag_in;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign rd_set = SET_AW'(request.set_index);
  assign set_q = SET_AW'(req_q.set_index);
  assign in_range = (32'(request.set_index) < SETS) &&
                    ((op_t'(request.op) == OP_VICTIM) || (32'(request.line_way) < WAYS));
  assign wr_mem = (state == S_FIN) && !ign;
  assign scan_start = (state == S_RD) && !ign && (op_t'(req_q.op) == OP_VICTIM);
  assign w = WAY_AW'(req_q.line_way);
  assign tag_in = TAG_BITS'(req_q.line_tag);

  slru_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_row_ram (
    .clk   (clk),
    .we    (wr_mem),
    .waddr (set_q),
    .wdata ({ref_n, time_n, tag_n}),
    .raddr (rd_set),
    .rdata (row_rdata)
  );

  slru_ram #(.WIDTH(EP_W), .DEPTH(SETS)) u_ep_ram (
    .clk   (clk),
    .we    (wr_mem),
    .waddr (set_q),
    .wdata (ep_n),
    .raddr (rd_set),
    .rdata (ep_rdata)
  );

  slru_scan #(.WAYS(WAYS)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_start),
    .ref_bits (ref_q),
    .times    (time_q),
    .res      (scan_res)
  );

  // sequence one request
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_RD;
      S_RD: begin
        if (scan_start) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SCAN: if (scan_res.done) state_next = S_FIN;
      S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // modify the set row and episode
  always_comb begin
    ref_n = ref_q;
    time_n = time_q;
    tag_n = tag_q;
    ep_n = ep_q;
    lvl_res = lvl;
    lvl_next = lvl;
    vic = '0;
    byp = 1'b0;
    case (op_t'(req_q.op))
      OP_INV: begin
        time_n[w] = '0;
        ref_n[w] = 1'b0;
        if (ep_q.valid && ep_q.way == w) begin
          if (ep_q.virt && ep_q.skip) begin
            ep_n.skip = 1'b0;
          end else begin
            ep_n = '0;
          end
        end
      end
      OP_HIT: begin
        time_n[w] = req_q.time_now;
        ref_n[w] = 1'b1;
        if (ep_q.valid && ep_q.way == w) begin
          lvl_next = ep_q.virt ? level_raise(lvl, min_level) : level_lower(lvl, min_level);
          ep_n.valid = 1'b0;
        end
      end
      OP_FILL: begin
        time_n[w] = req_q.time_now;
        ref_n[w] = (promo_shift != 5'd0) && draw(req_q.random_a, promo_shift);
        tag_n[w] = tag_in;
        if (ep_q.valid && tag_in == ep_q.tag) begin
          lvl_next = ep_q.virt ? level_lower(lvl, min_level) : level_raise(lvl, min_level);
          ep_n.valid = 1'b0;
        end
      end
      OP_VICTIM: begin
        // resolve by returning tag first
        if (tag_in != '0 && ep_q.valid && tag_in == ep_q.tag) begin
          lvl_res = ep_q.virt ? level_lower(lvl, min_level) : level_raise(lvl, min_level);
          ep_n.valid = 1'b0;
        end
        lvl_next = lvl_res;
        if (scan_res.ref_found) begin
          vic = WAY_AW'(scan_res.ref_way);
          if (aging_en) begin
            ref_n[WAY_AW'(scan_res.ref_way)] = 1'b0;
          end
        end
        if (scan_res.nref_found) begin
          vic = WAY_AW'(scan_res.nref_way);
        end
        // open a real or virtual episode
        if (byp_en && lvl_res.on && tag_in != '0 && draw(req_q.random_a, lvl_res.level)) begin
          byp = 1'b1;
          ep_n.valid = 1'b1;
          ep_n.tag = tag_in;
          ep_n.way = vic;
          ep_n.virt = 1'b0;
          ep_n.skip = 1'b0;
        end else if (draw(req_q.random_b, virt_shift)) begin
          ep_n.valid = 1'b1;
          ep_n.tag = tag_q[vic];
          ep_n.way = vic;
          ep_n.virt = 1'b1;
          ep_n.skip = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control state and config
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      set_vld <= '0;
      result_valid <= 1'b0;
      promo_shift <= 5'd0;
      byp_en <= 1'b0;
      aging_en <= 1'b1;
      virt_shift <= 5'd4;
      min_level <= 5'd8;
      lvl.level <= 5'd0;
      lvl.on <= 1'b1;
    end else begin
      state <= state_next;
      result_valid <= (state == S_FIN);
      if (wr_mem) begin
        set_vld[set_q] <= 1'b1;
        lvl <= lvl_next;
      end
      if (wr_en) begin
        case (cfg_idx_t'(wr_index))
          CFG_PROMO_SHIFT: promo_shift <= wr_data;
          CFG_BYP_EN:      byp_en <= wr_data[0];
          CFG_AGING_EN:    aging_en <= wr_data[0];
          CFG_INIT_LEVEL:  lvl.level <= wr_data;
          CFG_VIRT_SHIFT:  virt_shift <= wr_data;
          CFG_MIN_LEVEL:   min_level <= wr_data;
          default: ;
        endcase
      end
    end
  end

  // hold the request, capture the row, drive the result
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
      ign <= !in_range;
    end
    if (state == S_RD) begin
      if (set_vld[set_q]) begin
        {ref_q, time_q, tag_q} <= row_rdata;
        ep_q <= ep_rdata;
      end else begin
        ref_q <= '0;
        time_q <= '0;
        tag_q <= '0;
        ep_q <= '0;
      end
    end
    if (state == S_FIN) begin
      result.victim_way <= ign ? 3'd0 : 3'(vic);
      result.bypass_fill <= ign ? 1'b0 : byp;
      result.bypass_level_out <= ign ? lvl.level : lvl_next.level;
    end
  end

endmodule

/* rtl/core/slru_ram.sv */
module slru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/slru_scan.sv */
module slru_scan import slru_pkg::*; #(
  parameter int WAYS = WAYS_DEF,
  localparam int WAY_AW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [WAYS-1:0]       ref_bits,
  input  logic [WAYS-1:0][31:0] times,
  output scan_res_t             res
);

  logic              run;
  logic [WAY_AW-1:0] cnt;
  logic [31:0]       ref_time;
  logic [31:0]       nref_time;
  logic [31:0]       t;
  logic              r;

  assign t = times[cnt];
  assign r = ref_bits[cnt];

  // step one way per cycle; strict compare keeps the lowest way on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      res.done <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= '0;
      res <= '0;
    end else begin
      res.done <= 1'b0;
      if (run) begin
        if (r) begin
          if (!res.ref_found || t < ref_time) begin
            res.ref_found <= 1'b1;
            res.ref_way <= 5'(cnt);
            ref_time <= t;
          end
        end else begin
          if (!res.nref_found || t < nref_time) begin
            res.nref_found <= 1'b1;
            res.nref_way <= 5'(cnt);
            nref_time <= t;
          end
        end
        if (cnt == WAY_AW'(WAYS - 1)) begin
          run <= 1'b0;
          res.done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule
